[hw/rtl/rtc3w_pkg.sv]
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types and constants shared by the three-wire RTC serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_CE_ON    = 4'd1,
        PH_CMD_LOW  = 4'd2,
        PH_CMD_HIGH = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_HIGH  = 4'd7,
        PH_TAIL     = 4'd8,
        PH_CE_OFF   = 4'd9
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ENABLE_HOLD = 2'd1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd50;
    localparam logic [9:0] ENABLE_HOLD_RST = 10'd200;

    localparam logic [4:0] BURST_ADDR = 5'h1f;
    localparam logic [7:0] CMD_MARK   = 8'h80;
    localparam int unsigned CMD_BITS  = 8;

    typedef struct packed {
        logic        kind;
        logic        is_read;
        logic        burst;
        logic [4:0]  address;
        logic [63:0] write_data;
        logic        io_in;
    } t_in_item;

    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        io_out;
        logic        io_drive;
        logic        busy_res;
        logic        done_res;
        logic [63:0] read_data;
    } t_out_item;

endpackage

[hw/rtl/rtc_three_wire_serial_master.sv]
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master
// Tick-driven master for a three-wire RTC link: chip enable, serial clock,
// bidirectional data. Every input request is one tick; each gives one result.
// ----------------------------------------------------------------------------
// The result request of an accepted tick request is registered and raised in the next cycle.
// Throughput: one tick per cycle unless stalled; the sequencer state and the
//   result register both advance in the accepting cycle; that register frees on take.
// Reset: sequencer idle, counters and shift registers cleared, timing
//   registers back to 50 / 200 ticks, result register empty.
module rtc_three_wire_serial_master #(
    parameter int unsigned BURST_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rtc3w_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rtc3w_pkg::t_out_item o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [9:0]           i_cfg_data
);
    import rtc3w_pkg::*;

    localparam logic [6:0] BURST_BITS = 7'(BURST_BYTES * 8);
    localparam logic [6:0] SINGLE_BITS = 7'd8;
    localparam logic [6:0] CMD_LAST = 7'(CMD_BITS - 1);

    logic [7:0]  r_half_period;
    logic [9:0]  r_enable_hold;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_tick_count, n_tick_count;
    logic [6:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_command_shift, n_command_shift;
    logic [63:0] r_data_shift, n_data_shift;
    logic [63:0] r_read_gather, n_read_gather;
    logic [1:0]  r_request_flags, n_request_flags;

    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        in_accept;
    logic [9:0]  seg_len;
    logic [9:0]  seg_len_eff;
    logic        seg_done;
    logic [10:0] tick_inc;
    logic [6:0]  data_bits;
    logic [7:0]  bit_inc;
    logic        done;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_enable_hold <= ENABLE_HOLD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_ENABLE_HOLD) begin
                r_enable_hold <= i_cfg_data;
            end
        end
    end

    // phase length and end-of-phase detect; zero length acts as one
    always_comb begin
        if (r_phase == PH_CE_ON || r_phase == PH_CE_OFF) begin
            seg_len = r_enable_hold;
        end else begin
            seg_len = {2'b00, r_half_period};
        end
        seg_len_eff = (seg_len == 10'd0) ? 10'd1 : seg_len;
        tick_inc    = {1'b0, r_tick_count} + 11'd1;
        seg_done    = tick_inc >= {1'b0, seg_len_eff};
        data_bits   = r_request_flags[1] ? BURST_BITS : SINGLE_BITS;
        bit_inc     = {1'b0, r_bit_count} + 8'd1;
    end

    // sequencer next state and pin levels
    always_comb begin
        n_phase         = r_phase;
        n_tick_count    = r_tick_count;
        n_bit_count     = r_bit_count;
        n_command_shift = r_command_shift;
        n_data_shift    = r_data_shift;
        n_read_gather   = r_read_gather;
        n_request_flags = r_request_flags;
        done            = 1'b0;

        if (r_phase != PH_IDLE) begin
            n_tick_count = seg_done ? 10'd0 : tick_inc[9:0];
        end

        unique case (r_phase)
            PH_IDLE: begin
                if (i_in.kind) begin
                    n_request_flags = {i_in.burst, i_in.is_read};
                    n_command_shift = CMD_MARK
                                    | {2'b00, (i_in.burst ? BURST_ADDR : i_in.address), 1'b0}
                                    | {7'd0, i_in.is_read};
                    n_data_shift    = i_in.burst ? i_in.write_data
                                                 : {56'd0, i_in.write_data[7:0]};
                    n_read_gather   = '0;
                    n_tick_count    = '0;
                    n_bit_count     = '0;
                    n_phase         = PH_CE_ON;
                end
            end
            PH_CE_ON: begin
                if (seg_done) begin
                    n_bit_count = '0;
                    n_phase     = PH_CMD_LOW;
                end
            end
            PH_CMD_LOW: begin
                if (seg_done) n_phase = PH_CMD_HIGH;
            end
            PH_CMD_HIGH: begin
                if (seg_done) begin
                    if (r_bit_count >= CMD_LAST) begin
                        n_bit_count = '0;
                        n_phase     = r_request_flags[0] ? PH_RD_LOW : PH_WR_LOW;
                    end else begin
                        n_bit_count = bit_inc[6:0];
                        n_phase     = PH_CMD_LOW;
                    end
                end
            end
            PH_WR_LOW: begin
                if (seg_done) n_phase = PH_WR_HIGH;
            end
            PH_RD_LOW: begin
                // sample on the tick the clock rises
                if (seg_done) begin
                    if (i_in.io_in) n_read_gather[r_bit_count[5:0]] = 1'b1;
                    n_phase = PH_RD_HIGH;
                end
            end
            PH_WR_HIGH, PH_RD_HIGH: begin
                if (seg_done) begin
                    if (bit_inc >= {1'b0, data_bits}) begin
                        n_bit_count = '0;
                        n_phase     = PH_TAIL;
                    end else begin
                        n_bit_count = bit_inc[6:0];
                        n_phase     = (r_phase == PH_RD_HIGH) ? PH_RD_LOW : PH_WR_LOW;
                    end
                end
            end
            PH_TAIL: begin
                if (seg_done) n_phase = PH_CE_OFF;
            end
            PH_CE_OFF: begin
                if (seg_done) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            default: begin
                n_phase      = PH_IDLE;
                n_tick_count = '0;
            end
        endcase

        n_out              = '0;
        n_out.busy_res     = (n_phase != PH_IDLE);
        n_out.done_res     = done;
        n_out.read_data    = (done && r_request_flags[0]) ? r_read_gather : 64'd0;
        unique case (n_phase)
            PH_CE_ON, PH_TAIL, PH_RD_LOW: begin
                n_out.chip_enable = 1'b1;
            end
            PH_RD_HIGH: begin
                n_out.chip_enable  = 1'b1;
                n_out.serial_clock = 1'b1;
            end
            PH_CMD_LOW, PH_CMD_HIGH: begin
                n_out.chip_enable  = 1'b1;
                n_out.io_drive     = 1'b1;
                n_out.serial_clock = (n_phase == PH_CMD_HIGH);
                n_out.io_out       = n_command_shift[n_bit_count[2:0]];
            end
            PH_WR_LOW, PH_WR_HIGH: begin
                n_out.chip_enable  = 1'b1;
                n_out.io_drive     = 1'b1;
                n_out.serial_clock = (n_phase == PH_WR_HIGH);
                n_out.io_out       = n_data_shift[n_bit_count[5:0]];
            end
            default: begin
                n_out.chip_enable = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_tick_count    <= '0;
            r_bit_count     <= '0;
            r_command_shift <= '0;
            r_data_shift    <= '0;
            r_read_gather   <= '0;
            r_request_flags <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase         <= n_phase;
                r_tick_count    <= n_tick_count;
                r_bit_count     <= n_bit_count;
                r_command_shift <= n_command_shift;
                r_data_shift    <= n_data_shift;
                r_read_gather   <= n_read_gather;
                r_request_flags <= n_request_flags;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // idle always leaves the tick counter cleared
    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick_count == 10'd0)
        else $error("tick counter not clear in idle");

    // done ends the session
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res && !r_out.chip_enable)
        else $error("done while still busy");

    // data pin is only driven with chip enable up
    a_drive_needs_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.io_drive |-> r_out.chip_enable)
        else $error("data pin driven without chip enable");

    // a taken tick always yields a held result request next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule
